FILE: design/rocm_pkg.sv
// rocm_pkg: shared types and constants for the recursive oscillator cosine mixer.
// Holds the payload structs, the register index codes and the register reset values.
// No dependencies.
`timescale 1ns / 1ps

package rocm_pkg;

    localparam int SAMPLE_BITS  = 24;
    localparam int OSC_BITS     = 32;
    localparam int CFG_IDX_BITS = 8;

    // Wide enough for a sum of two 32x32 products plus the rounding offset.
    localparam int ACC_BITS = 66;

    localparam logic signed [OSC_BITS-1:0] OSC_UNITY = 32'sh4000_0000;
    localparam logic signed [OSC_BITS-1:0] OSC_ZERO  = 32'sh0000_0000;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_START_COS = 8'd0,
        REG_START_SIN = 8'd1,
        REG_STEP_COS  = 8'd2,
        REG_STEP_SIN  = 8'd3
    } cfg_idx_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          is_last;
    } mix_in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] product;
        logic                          last_out;
    } mix_out_t;

    typedef struct packed {
        logic signed [OSC_BITS-1:0] start_cos;
        logic signed [OSC_BITS-1:0] start_sin;
        logic signed [OSC_BITS-1:0] step_cos;
        logic signed [OSC_BITS-1:0] step_sin;
    } osc_cfg_t;

endpackage

FILE: design/recursive_oscillator_cosine_mixer_top.sv
// Recursive oscillator cosine mixer, top level: input register, mixer, oscillator,
// output register and config register file. Depends on rocm_pkg, rocm_cfg_regs,
// rocm_osc and rocm_mixer.
`timescale 1ns / 1ps

// Each sample transaction on s_ is multiplied by the cosine of a recursive rotation
// oscillator and leaves on m_ as one result transaction, product rounded half up and
// saturated to 24 bits, with last_out copying is_last. The block takes one transaction
// per clock while m_ is not stalled; each accepted sample passes through the input
// register and then the output register before it appears on m_. The rate is set by
// the oscillator loop: four 32x32 multiplies, two sums, round and saturate per sample
// from its state registers back into themselves. The cosine/sine pair
// reloads from start_cos/start_sin on the first sample after reset and after each
// sample marked is_last. Registers (cfg_index): 0 start_cos, 1 start_sin, 2 step_cos,
// 3 step_sin, all signed fixed point with OSC_FRAC_BITS fraction bits; other indexes
// are ignored. cfg_ready is always high. Write the config only while the block is idle.

module recursive_oscillator_cosine_mixer_top #(
    parameter int OSC_FRAC_BITS = 30
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  rocm_pkg::mix_in_t                 s_data,

    output logic                              m_valid,
    input  logic                              m_ready,
    output rocm_pkg::mix_out_t                m_data,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rocm_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [rocm_pkg::OSC_BITS-1:0]     cfg_data
);
    import rocm_pkg::*;

    osc_cfg_t                   cfg;
    mix_in_t                    in_reg;
    logic                       in_valid_reg;
    mix_out_t                   out_reg;
    logic                       out_valid_reg;
    logic                       move;
    logic signed [OSC_BITS-1:0] cur_cos;
    logic signed [SAMPLE_BITS-1:0] product;

    assign cfg_ready = 1'b1;

    rocm_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_write (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Held sample moves to the output register when that slot is free or draining.
    assign move    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || move;

    // Oscillator steps exactly once per sample moved to the output.
    rocm_osc #(
        .OSC_FRAC_BITS (OSC_FRAC_BITS)
    ) u_osc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (move),
        .is_last (in_reg.is_last),
        .cfg     (cfg),
        .cur_cos (cur_cos)
    );

    rocm_mixer #(
        .OSC_FRAC_BITS (OSC_FRAC_BITS)
    ) u_mix (
        .sample  (in_reg.sample),
        .cos_val (cur_cos),
        .product (product)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (move) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (move) begin
            out_reg.product  <= product;
            out_reg.last_out <= in_reg.is_last;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

FILE: design/rocm_cfg_regs.sv
// rocm_cfg_regs: start and step register file written over the config channel.
// Depends on rocm_pkg. Writes to unknown indexes are dropped.
`timescale 1ns / 1ps

module rocm_cfg_regs (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_write,
    input  logic [rocm_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [rocm_pkg::OSC_BITS-1:0]        cfg_data,
    output rocm_pkg::osc_cfg_t                   cfg
);
    import rocm_pkg::*;

    osc_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_cos <= OSC_UNITY;
            cfg_reg.start_sin <= OSC_ZERO;
            cfg_reg.step_cos  <= OSC_UNITY;
            cfg_reg.step_sin  <= OSC_ZERO;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_START_COS: cfg_reg.start_cos <= cfg_data;
                REG_START_SIN: cfg_reg.start_sin <= cfg_data;
                REG_STEP_COS:  cfg_reg.step_cos  <= cfg_data;
                REG_STEP_SIN:  cfg_reg.step_sin  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: design/rocm_osc.sv
// rocm_osc: recursive rotation oscillator, one rotation per advance.
// Depends on rocm_pkg. Reloads from the start values after reset and after a last sample.
`timescale 1ns / 1ps

module rocm_osc #(
    parameter int OSC_FRAC_BITS = 30
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 advance,
    input  logic                                 is_last,
    input  rocm_pkg::osc_cfg_t                   cfg,
    output logic signed [rocm_pkg::OSC_BITS-1:0] cur_cos
);
    import rocm_pkg::*;

    localparam logic signed [ACC_BITS-1:0] HALF =
        ACC_BITS'(1) <<< (OSC_FRAC_BITS - 1);

    // Round half up, then clamp to the 32-bit signed range.
    function automatic logic signed [OSC_BITS-1:0] round_sat(
        input logic signed [ACC_BITS-1:0] acc
    );
        logic signed [ACC_BITS-1:0] r;
        logic [ACC_BITS-OSC_BITS:0]  top;
        begin
            r   = (acc + HALF) >>> OSC_FRAC_BITS;
            top = r[ACC_BITS-1:OSC_BITS-1];
            if (top != '0 && top != '1) begin
                round_sat = r[ACC_BITS-1] ? {1'b1, {(OSC_BITS-1){1'b0}}}
                                          : {1'b0, {(OSC_BITS-1){1'b1}}};
            end else begin
                round_sat = r[OSC_BITS-1:0];
            end
        end
    endfunction

    logic signed [OSC_BITS-1:0]   osc_cos_reg, osc_sin_reg;
    logic signed [OSC_BITS-1:0]   osc_cos_next, osc_sin_next;
    logic                         restart_reg;
    logic signed [OSC_BITS-1:0]   cur_sin;
    logic signed [2*OSC_BITS-1:0] p_cc, p_ss, p_sc, p_cs;

    assign cur_cos = restart_reg ? cfg.start_cos : osc_cos_reg;
    assign cur_sin = restart_reg ? cfg.start_sin : osc_sin_reg;

    assign p_cc = cur_cos * cfg.step_cos;
    assign p_ss = cur_sin * cfg.step_sin;
    assign p_sc = cur_sin * cfg.step_cos;
    assign p_cs = cur_cos * cfg.step_sin;

    always_comb begin
        osc_cos_next = round_sat(ACC_BITS'(p_cc) - ACC_BITS'(p_ss));
        osc_sin_next = round_sat(ACC_BITS'(p_sc) + ACC_BITS'(p_cs));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            osc_cos_reg <= OSC_ZERO;
            osc_sin_reg <= OSC_ZERO;
            restart_reg <= 1'b1;
        end else if (advance) begin
            osc_cos_reg <= osc_cos_next;
            osc_sin_reg <= osc_sin_next;
            restart_reg <= is_last;
        end
    end

endmodule

FILE: design/rocm_mixer.sv
// rocm_mixer: sample times oscillator cosine, rounded half up and saturated.
// Depends on rocm_pkg.
`timescale 1ns / 1ps

module rocm_mixer #(
    parameter int OSC_FRAC_BITS = 30
) (
    input  logic signed [rocm_pkg::SAMPLE_BITS-1:0] sample,
    input  logic signed [rocm_pkg::OSC_BITS-1:0]    cos_val,
    output logic signed [rocm_pkg::SAMPLE_BITS-1:0] product
);
    import rocm_pkg::*;

    localparam int PROD_BITS = SAMPLE_BITS + OSC_BITS;
    localparam logic signed [ACC_BITS-1:0] HALF =
        ACC_BITS'(1) <<< (OSC_FRAC_BITS - 1);

    logic signed [PROD_BITS-1:0]   p;
    logic signed [ACC_BITS-1:0]    r;
    logic [ACC_BITS-SAMPLE_BITS:0] top;

    assign p   = sample * cos_val;
    assign r   = (ACC_BITS'(p) + HALF) >>> OSC_FRAC_BITS;
    assign top = r[ACC_BITS-1:SAMPLE_BITS-1];

    always_comb begin
        if (top != '0 && top != '1) begin
            product = r[ACC_BITS-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                    : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end else begin
            product = r[SAMPLE_BITS-1:0];
        end
    end

endmodule

FILE: design/rocm_checker.sv
// rocm_checker: port-level assertions for the mixer top, bound to it below.
// Depends on rocm_pkg and recursive_oscillator_cosine_mixer_top.
`timescale 1ns / 1ps

module rocm_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input rocm_pkg::mix_out_t m_data,
    input logic               cfg_ready
);
    import rocm_pkg::*;

    // Result transaction holds until taken.
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or dropped while stalled");

    // Input only back-pressures when the output slot is full and stalled.
    a_s_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled with output free");

    // Coming out of reset both stages are empty.
    a_reset_empty: assert property (@(posedge aclk)
        $rose(aresetn) |-> !m_valid && s_ready)
        else $error("pipeline not empty after reset");

    // Config channel never stalls.
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("config channel stalled");

endmodule

bind recursive_oscillator_cosine_mixer_top rocm_checker u_rocm_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data),
    .cfg_ready (cfg_ready)
);
